// File: rtl/ecg_notch_leadoff_framer_unit_assert.svh
// assertion helpers used by the framer unit rtl file
`ifndef ECG_NOTCH_LEADOFF_FRAMER_UNIT_ASSERT_SVH
`define ECG_NOTCH_LEADOFF_FRAMER_UNIT_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define ECG_NLF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// condition in one cycle that implies another in the next cycle
`define ECG_NLF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ecg_nlf_pkg.sv
package ecg_nlf_pkg;

   // field widths
   localparam int SAMPLE_W   = 12;
   localparam int FILT_W     = 16;
   localparam int COEF_W     = 15;
   localparam int LEN_W      = 11;
   localparam int COUNT_W    = 10;
   localparam int HIST_W     = 26;
   localparam int MAX_BATCH  = 1024;

   // default fixed point layout
   localparam int DEF_COEF_FRAC_BITS = 14;
   localparam int DEF_HIST_FRAC_BITS = 8;

   // register reset values
   localparam logic [COEF_W-1:0] ZERO_COEF_RST    = COEF_W'(10125);
   localparam logic [COEF_W-1:0] POLE_COEF1_RST   = COEF_W'(9620);
   localparam logic [COEF_W-1:0] POLE_COEF2_RST   = COEF_W'(14787);
   localparam logic [LEN_W-1:0]  BATCH_LENGTH_RST = LEN_W'(250);

   // control register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_ZERO_COEF    = 2'd0,
      CSR_POLE_COEF1   = 2'd1,
      CSR_POLE_COEF2   = 2'd2,
      CSR_BATCH_LENGTH = 2'd3
   } csr_index_type;

endpackage

// File: rtl/ecg_nlf_if.sv
// request channel: one converter sample with its lead-off flags
interface ecg_nlf_req_if import ecg_nlf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                lead_plus_off;
   logic                lead_minus_off;

   modport source (output valid, sample, lead_plus_off, lead_minus_off, input ready);
   modport sink   (input valid, sample, lead_plus_off, lead_minus_off, output ready);
endinterface

// result channel: one filtered sample with its framing flags
interface ecg_nlf_rsp_if import ecg_nlf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [FILT_W-1:0] filtered;
   logic                     leads_off;
   logic                     batch_last;

   modport source (output valid, filtered, leads_off, batch_last, input ready);
   modport sink   (input valid, filtered, leads_off, batch_last, output ready);
endinterface

// File: rtl/ecg_notch_leadoff_framer_unit.sv
// an accepted request passes through the input stage register and then the result
//    register, moving on when the result register is free or being taken
// one request per cycle while results are taken; the feedback path is the multiply-add
//    on the previous output in the result stage, done once per sample
// reset (synchronous, active high) empties both stages, clears filter history and
//    batch counter, and loads the coefficient and batch length defaults
`include "ecg_notch_leadoff_framer_unit_assert.svh"

module ecg_notch_leadoff_framer_unit import ecg_nlf_pkg::*; #(
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
   parameter int HIST_FRAC_BITS = DEF_HIST_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   ecg_nlf_req_if.sink           req_if,
   ecg_nlf_rsp_if.source         rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // accumulator sizing
   localparam int SHIFT_X  = COEF_FRAC_BITS + HIST_FRAC_BITS;
   localparam int XTERM_W  = SAMPLE_W + SHIFT_X;
   localparam int ZPROD_W  = COEF_W + SAMPLE_W;
   localparam int ZTERM_W  = ZPROD_W + HIST_FRAC_BITS;
   localparam int PROD_W   = COEF_W + 1 + HIST_W;
   localparam int TERM_W0  = (XTERM_W > ZTERM_W) ? XTERM_W : ZTERM_W;
   localparam int TERM_W   = (TERM_W0 > PROD_W) ? TERM_W0 : PROD_W;
   localparam int ACC_W    = TERM_W + 4;

   localparam logic signed [ACC_W-1:0] COEF_ROUND =
      ACC_W'((longint'(1) << COEF_FRAC_BITS) - 1);
   localparam logic signed [ACC_W-1:0] HIST_MAX_ACC =
      ACC_W'((longint'(1) << (HIST_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] HIST_MIN_ACC =
      ACC_W'(-(longint'(1) << (HIST_W - 1)));
   localparam logic signed [HIST_W-1:0] HIST_ROUND =
      HIST_W'((longint'(1) << HIST_FRAC_BITS) - 1);
   localparam logic signed [HIST_W-1:0] FILT_MAX_H =
      HIST_W'((longint'(1) << (FILT_W - 1)) - 1);
   localparam logic signed [HIST_W-1:0] FILT_MIN_H =
      HIST_W'(-(longint'(1) << (FILT_W - 1)));

   // control registers
   logic [COEF_W-1:0] zero_coef_ff, zero_coef_in;
   logic [COEF_W-1:0] pole_coef1_ff, pole_coef1_in;
   logic [COEF_W-1:0] pole_coef2_ff, pole_coef2_in;
   logic [LEN_W-1:0]  batch_length_ff, batch_length_in;

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-1:0] s1_sample_ff, s1_sample_in;
   logic                s1_off_ff, s1_off_in;

   // result stage
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [FILT_W-1:0] filtered_ff, filtered_in;
   logic                     leads_off_ff, leads_off_in;
   logic                     batch_last_ff, batch_last_in;

   // filter history and batch counter
   logic [SAMPLE_W-1:0]      in_hist1_ff, in_hist1_in;
   logic [SAMPLE_W-1:0]      in_hist2_ff, in_hist2_in;
   logic signed [HIST_W-1:0] out_hist1_ff, out_hist1_in;
   logic signed [HIST_W-1:0] out_hist2_ff, out_hist2_in;
   logic [COUNT_W-1:0]       batch_count_ff, batch_count_in;

   logic          csr_write;
   csr_index_type csr_index;
   logic          req_accept;
   logic          s1_advance;

   logic [ZPROD_W-1:0]       z_prod;
   logic signed [PROD_W-1:0] p1_prod;
   logic signed [PROD_W-1:0] p2_prod;
   logic signed [ACC_W-1:0]  x0_term;
   logic signed [ACC_W-1:0]  x2_term;
   logic signed [ACC_W-1:0]  z_term;
   logic signed [ACC_W-1:0]  p1_term;
   logic signed [ACC_W-1:0]  p2_term;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_biased;
   logic signed [ACC_W-1:0]  quot;
   logic signed [HIST_W-1:0] y_new;
   logic signed [HIST_W-1:0] y_biased;
   logic signed [HIST_W-1:0] y_int;
   logic signed [HIST_W-1:0] y_clamped;
   logic [LEN_W-1:0]         eff_len;
   logic [LEN_W-1:0]         count_inc;
   logic                     last;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // register write decode
   always_comb begin
      zero_coef_in    = zero_coef_ff;
      pole_coef1_in   = pole_coef1_ff;
      pole_coef2_in   = pole_coef2_ff;
      batch_length_in = batch_length_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ZERO_COEF:    zero_coef_in    = csr_pwdata[COEF_W-1:0];
            CSR_POLE_COEF1:   pole_coef1_in   = csr_pwdata[COEF_W-1:0];
            CSR_POLE_COEF2:   pole_coef2_in   = csr_pwdata[COEF_W-1:0];
            CSR_BATCH_LENGTH: batch_length_in = csr_pwdata[LEN_W-1:0];
            default:          zero_coef_in    = zero_coef_ff;
         endcase
      end
   end

   // register read mux
   always_comb begin
      unique case (csr_index)
         CSR_ZERO_COEF:    csr_prdata = CSR_DATA_W'(zero_coef_ff);
         CSR_POLE_COEF1:   csr_prdata = CSR_DATA_W'(pole_coef1_ff);
         CSR_POLE_COEF2:   csr_prdata = CSR_DATA_W'(pole_coef2_ff);
         CSR_BATCH_LENGTH: csr_prdata = CSR_DATA_W'(batch_length_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // handshake: input stage moves on when the result register is free or being taken
   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || s1_advance;
   assign req_accept    = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign s1_sample_in = req_accept ? req_if.sample : s1_sample_ff;
   assign s1_off_in    = req_accept ? (req_if.lead_plus_off || req_if.lead_minus_off)
                                    : s1_off_ff;
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   // filter terms, all in units of the combined fraction
   always_comb begin
      z_prod  = zero_coef_ff * in_hist1_ff;
      p1_prod = signed'({1'b0, pole_coef1_ff}) * out_hist1_ff;
      p2_prod = signed'({1'b0, pole_coef2_ff}) * out_hist2_ff;
      x0_term = signed'(ACC_W'(s1_sample_ff)) <<< SHIFT_X;
      x2_term = signed'(ACC_W'(in_hist2_ff)) <<< SHIFT_X;
      z_term  = signed'(ACC_W'(z_prod)) <<< HIST_FRAC_BITS;
      p1_term = {{(ACC_W-PROD_W){p1_prod[PROD_W-1]}}, p1_prod};
      p2_term = {{(ACC_W-PROD_W){p2_prod[PROD_W-1]}}, p2_prod};
      acc     = x0_term - z_term + x2_term + p1_term - p2_term;
   end

   // scale back to history format, truncating toward zero, then saturate
   always_comb begin
      acc_biased = acc + (acc[ACC_W-1] ? COEF_ROUND : '0);
      quot       = acc_biased >>> COEF_FRAC_BITS;
      if (quot > HIST_MAX_ACC) begin
         y_new = HIST_MAX_ACC[HIST_W-1:0];
      end else if (quot < HIST_MIN_ACC) begin
         y_new = HIST_MIN_ACC[HIST_W-1:0];
      end else begin
         y_new = quot[HIST_W-1:0];
      end
   end

   // integer part of the new output, saturated to the result range
   always_comb begin
      y_biased = y_new + (y_new[HIST_W-1] ? HIST_ROUND : '0);
      y_int    = y_biased >>> HIST_FRAC_BITS;
      if (y_int > FILT_MAX_H) begin
         y_clamped = FILT_MAX_H;
      end else if (y_int < FILT_MIN_H) begin
         y_clamped = FILT_MIN_H;
      end else begin
         y_clamped = y_int;
      end
   end

   // batch framing
   always_comb begin
      if (batch_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (batch_length_ff > LEN_W'(MAX_BATCH)) begin
         eff_len = LEN_W'(MAX_BATCH);
      end else begin
         eff_len = batch_length_ff;
      end
      count_inc = {1'b0, batch_count_ff} + LEN_W'(1);
      last      = count_inc >= eff_len;
   end

   // state updates for the sample leaving the input stage
   always_comb begin
      in_hist1_in    = in_hist1_ff;
      in_hist2_in    = in_hist2_ff;
      out_hist1_in   = out_hist1_ff;
      out_hist2_in   = out_hist2_ff;
      batch_count_in = batch_count_ff;
      filtered_in    = filtered_ff;
      leads_off_in   = leads_off_ff;
      batch_last_in  = batch_last_ff;
      if (s1_advance) begin
         batch_count_in = last ? '0 : count_inc[COUNT_W-1:0];
         leads_off_in   = s1_off_ff;
         batch_last_in  = last;
         filtered_in    = s1_off_ff ? '0 : y_clamped[FILT_W-1:0];
         if (!s1_off_ff) begin
            in_hist1_in  = s1_sample_ff;
            in_hist2_in  = in_hist1_ff;
            out_hist1_in = y_new;
            out_hist2_in = out_hist1_ff;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_coef_ff    <= ZERO_COEF_RST;
         pole_coef1_ff   <= POLE_COEF1_RST;
         pole_coef2_ff   <= POLE_COEF2_RST;
         batch_length_ff <= BATCH_LENGTH_RST;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         in_hist1_ff     <= '0;
         in_hist2_ff     <= '0;
         out_hist1_ff    <= '0;
         out_hist2_ff    <= '0;
         batch_count_ff  <= '0;
      end else begin
         zero_coef_ff    <= zero_coef_in;
         pole_coef1_ff   <= pole_coef1_in;
         pole_coef2_ff   <= pole_coef2_in;
         batch_length_ff <= batch_length_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         in_hist1_ff     <= in_hist1_in;
         in_hist2_ff     <= in_hist2_in;
         out_hist1_ff    <= out_hist1_in;
         out_hist2_ff    <= out_hist2_in;
         batch_count_ff  <= batch_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_sample_ff  <= s1_sample_in;
      s1_off_ff     <= s1_off_in;
      filtered_ff   <= filtered_in;
      leads_off_ff  <= leads_off_in;
      batch_last_ff <= batch_last_in;
   end

   // result channel
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.filtered   = filtered_ff;
   assign rsp_if.leads_off  = leads_off_ff;
   assign rsp_if.batch_last = batch_last_ff;

   // checks
   `ECG_NLF_ASSERT_NEXT(a_hold_history, !s1_advance,
      $stable(out_hist1_ff) && $stable(in_hist1_ff) && $stable(batch_count_ff),
      "filter state changed without a sample leaving the input stage")
   `ECG_NLF_ASSERT_NEXT(a_leadoff_keeps_history, s1_advance && s1_off_ff,
      $stable(out_hist1_ff) && $stable(out_hist2_ff) && $stable(in_hist2_ff),
      "lead-off sample disturbed the filter history")
   `ECG_NLF_ASSERT_ALWAYS(a_leadoff_zero,
      !rsp_valid_ff || !leads_off_ff || filtered_ff == '0,
      "lead-off result is not zero")
   `ECG_NLF_ASSERT_ALWAYS(a_stall_cause,
      req_if.ready || (s1_valid_ff && rsp_valid_ff && !rsp_if.ready),
      "request refused while a stage was free")

endmodule

// File: tb/ecg_nlf_result_check.sv
module ecg_nlf_result_check import ecg_nlf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ecg_nlf_req_if                req_if,
   ecg_nlf_rsp_if                rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CFB        = DEF_COEF_FRAC_BITS;
   localparam int     HFB        = DEF_HIST_FRAC_BITS;
   localparam longint UNIT_X     = 64'sd1 <<< (CFB + HFB);
   localparam longint UNIT_H     = 64'sd1 <<< HFB;
   localparam longint UNIT_C     = 64'sd1 <<< CFB;
   localparam longint HIST_HI    = (64'sd1 <<< (HIST_W - 1)) - 1;
   localparam longint HIST_LO    = -(64'sd1 <<< (HIST_W - 1));

   typedef struct packed {
      logic signed [FILT_W-1:0] filtered;
      logic                     leads_off;
      logic                     batch_last;
   } notch_result_type;

   // shadow copy of the control registers
   logic [COEF_W-1:0]   coef_zero;
   logic [COEF_W-1:0]   coef_pole1;
   logic [COEF_W-1:0]   coef_pole2;
   logic [LEN_W-1:0]    frame_len;

   // filter history and batch position
   logic [SAMPLE_W-1:0] x_prev1;
   logic [SAMPLE_W-1:0] x_prev2;
   longint              y_prev1;
   longint              y_prev2;
   logic [COUNT_W-1:0]  frame_pos;

   notch_result_type    predicted_q[$];

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // one filter step: updates the history and batch position, returns the result
   function automatic notch_result_type notch_step(input logic [SAMPLE_W-1:0] x0,
                                                   input logic off);
      notch_result_type r;
      longint           acc;
      longint           y;
      int               span;
      r = '0;
      r.leads_off = off;
      // history frozen while a lead is off
      if (!off) begin
         acc = longint'(x0) * UNIT_X
             - longint'(coef_zero) * longint'(x_prev1) * UNIT_H
             + longint'(x_prev2) * UNIT_X
             + longint'(coef_pole1) * y_prev1
             - longint'(coef_pole2) * y_prev2;
         y = clip(acc / UNIT_C, HIST_LO, HIST_HI);
         x_prev2 = x_prev1;
         x_prev1 = x0;
         y_prev2 = y_prev1;
         y_prev1 = y;
         r.filtered = FILT_W'(clip(y / UNIT_H, -32768, 32767));
      end
      // batch length of zero acts as one, anything past the maximum as the maximum
      if (frame_len == '0) span = 1;
      else if (frame_len > MAX_BATCH) span = MAX_BATCH;
      else span = int'(frame_len);
      r.batch_last = (int'(frame_pos) + 1) >= span;
      frame_pos = r.batch_last ? '0 : frame_pos + 1'b1;
      return r;
   endfunction

   function automatic int check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
      if (got === want) return 0;
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      notch_result_type seen;
      notch_result_type wanted;
      int               faults;
      int               pushed;
      int               popped;
      faults = 0;
      pushed = 0;
      popped = 0;
      if (reset) begin
         coef_zero  = ZERO_COEF_RST;
         coef_pole1 = POLE_COEF1_RST;
         coef_pole2 = POLE_COEF2_RST;
         frame_len  = BATCH_LENGTH_RST;
         x_prev1    = '0;
         x_prev2    = '0;
         y_prev1    = 0;
         y_prev2    = 0;
         frame_pos  = '0;
         predicted_q.delete();
         results_owed <= 0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               CSR_ZERO_COEF:    coef_zero  = csr_pwdata[COEF_W-1:0];
               CSR_POLE_COEF1:   coef_pole1 = csr_pwdata[COEF_W-1:0];
               CSR_POLE_COEF2:   coef_pole2 = csr_pwdata[COEF_W-1:0];
               CSR_BATCH_LENGTH: frame_len  = csr_pwdata[LEN_W-1:0];
               default: ;
            endcase
         end
         // compare an accepted result against the oldest prediction
         if (rsp_if.valid && rsp_if.ready) begin
            seen.filtered   = rsp_if.filtered;
            seen.leads_off  = rsp_if.leads_off;
            seen.batch_last = rsp_if.batch_last;
            if (predicted_q.size() == 0) begin
               $error("result with nothing predicted: filtered %0d leads_off %0b batch_last %0b",
                      seen.filtered, seen.leads_off, seen.batch_last);
               faults++;
            end else begin
               wanted = predicted_q.pop_front();
               popped = 1;
               faults += check_field("filtered", wanted.filtered, seen.filtered);
               faults += check_field("leads_off", wanted.leads_off, seen.leads_off);
               faults += check_field("batch_last", wanted.batch_last, seen.batch_last);
            end
         end
         // predict for an accepted request
         if (req_if.valid && req_if.ready) begin
            predicted_q.push_back(notch_step(req_if.sample,
                                             req_if.lead_plus_off || req_if.lead_minus_off));
            pushed = 1;
         end
         mismatch_count <= mismatch_count + faults;
         results_owed   <= results_owed + pushed - popped;
      end
   end

endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ecg_nlf_pkg::*;

   localparam int SAMPLES_TOTAL  = 1350;
   localparam int SETTLE_SAMPLES = 200;
   localparam int COEF_MAX       = (1 << COEF_W) - 1;
   localparam int LEN_MAX        = (1 << LEN_W) - 1;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int HOLD_CYCLES    = 100;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    mismatch_count;
   int                    results_owed;
   int                    idle_odds;
   bit                    settle_mode;
   bit                    hold_wanted;
   bit                    hold_done;
   int                    level;

   ecg_nlf_req_if req_ch ();
   ecg_nlf_rsp_if rsp_ch ();

   ecg_notch_leadoff_framer_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ecg_nlf_result_check result_check (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // 50 MHz clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // hard stop
   initial begin
      #10ms;
      $display("Mismatches found");
      $finish;
   end

   // register value with random bits above the field
   function automatic logic [CSR_DATA_W-1:0] with_noise(input int unsigned v, input int w);
      logic [CSR_DATA_W-1:0] mask;
      mask = (CSR_DATA_W'(1) << w) - 1'b1;
      return (CSR_DATA_W'($urandom()) & ~mask) | (CSR_DATA_W'(v) & mask);
   endfunction

   // setup and access phase; psel stays up for back-to-back writes
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] word);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // drain the pipeline, then load all four registers
   task automatic program_filter(input int unsigned zc, input int unsigned p1,
                                 input int unsigned p2, input int unsigned len);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      csr_write(CSR_ZERO_COEF, with_noise(zc, COEF_W));
      csr_write(CSR_POLE_COEF1, with_noise(p1, COEF_W));
      csr_write(CSR_POLE_COEF2, with_noise(p2, COEF_W));
      csr_write(CSR_BATCH_LENGTH, with_noise(len, LEN_W));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // offer one request, with an occasional gap in front of it
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic plus_off,
                              input logic minus_off);
      if (!settle_mode && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_ch.valid  <= 1'b0;
         req_ch.sample <= SAMPLE_W'($urandom());
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.sample         <= s;
      req_ch.lead_plus_off  <= plus_off;
      req_ch.lead_minus_off <= minus_off;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // mostly a wandering trace with beats, some raw noise and lead-off episodes
   task automatic send_random_sample();
      int                  pick;
      logic [SAMPLE_W-1:0] s;
      logic [1:0]          off;
      pick = $urandom_range(0, 99);
      off  = 2'b00;
      if (pick < 8) begin
         s   = SAMPLE_W'($urandom());
         off = 2'($urandom_range(1, 3));
      end else if (pick < 22) begin
         s = SAMPLE_W'($urandom());
      end else begin
         level += int'($urandom_range(0, 64)) - 32;
         if (pick >= 96) level += (pick % 2 == 0) ? 1200 : -1200;
         if (level < 0) level = 0;
         if (level > 4095) level = 4095;
         s = SAMPLE_W'(level);
      end
      send_sample(s, off[1], off[0]);
   endtask

   // result side: random stalls, one long hold-off, none at the end
   initial begin : result_drain
      int stall_odds;
      int tick;
      rsp_ch.ready <= 1'b0;
      stall_odds = 8;
      tick = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 64 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_odds = 0;
               1: stall_odds = 3;
               default: stall_odds = 12;
            endcase
         end
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (!settle_mode && stall_odds != 0 &&
                      $urandom_range(1, stall_odds) == 1) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 16)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int          sent;
      int          phase_len;
      int          remaining;
      int          guard;
      int unsigned c_zero;
      int unsigned c_pole1;
      int unsigned c_pole2;
      int unsigned len;

      reset                 <= 1'b1;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.sample         <= '0;
      req_ch.lead_plus_off  <= 1'b0;
      req_ch.lead_minus_off <= 1'b0;
      idle_odds   = 3;
      settle_mode = 1'b0;
      hold_wanted = 1'b0;
      hold_done   = 1'b0;
      level       = 2048;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: sample extremes and every lead-off combination
      send_sample(12'd0, 1'b0, 1'b0);
      send_sample(12'd4095, 1'b0, 1'b0);
      send_sample(12'd4095, 1'b0, 1'b0);
      send_sample(12'd0, 1'b0, 1'b0);
      send_sample(12'd2730, 1'b1, 1'b0);
      send_sample(12'd1365, 1'b0, 1'b1);
      send_sample(12'd4095, 1'b1, 1'b1);
      send_sample(12'd2048, 1'b0, 1'b0);
      send_sample(12'd1365, 1'b0, 1'b0);

      // runaway upwards into positive saturation; zero length, count already past it
      program_filter(0, COEF_MAX, 0, 0);
      repeat (8) send_sample(12'd4095, 1'b0, 1'b0);

      // growing oscillation into both limits; length above the maximum
      program_filter(COEF_MAX, 0, COEF_MAX, LEN_MAX);
      for (int i = 0; i < 8; i++) send_sample((i % 2 == 0) ? 12'd4095 : 12'd0, 1'b0, 1'b0);

      // random phases, each with its own register setting
      sent = 0;
      while (sent < SAMPLES_TOTAL) begin
         case ($urandom_range(0, 3))
            0: begin
               c_zero  = ZERO_COEF_RST;
               c_pole1 = POLE_COEF1_RST;
               c_pole2 = POLE_COEF2_RST;
            end
            1: begin
               c_zero  = $urandom_range(0, COEF_MAX);
               c_pole2 = $urandom_range(8000, 16000);
               c_pole1 = $urandom_range(0, 16383 + c_pole2);
            end
            2: begin
               c_zero  = $urandom_range(0, COEF_MAX);
               c_pole1 = $urandom_range(0, COEF_MAX);
               c_pole2 = $urandom_range(0, COEF_MAX);
            end
            default: begin
               c_zero  = $urandom_range(0, 1) * COEF_MAX;
               c_pole1 = $urandom_range(0, 1) * COEF_MAX;
               c_pole2 = $urandom_range(0, 1) * COEF_MAX;
            end
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: len = $urandom_range(1, 16);
            4, 5, 6:    len = $urandom_range(17, 300);
            7:          len = 0;
            8:          len = MAX_BATCH;
            default:    len = $urandom_range(MAX_BATCH + 1, LEN_MAX);
         endcase
         program_filter(c_zero, c_pole1, c_pole2, len);

         remaining = SAMPLES_TOTAL - sent;
         phase_len = $urandom_range(80, 220);
         if (remaining <= SETTLE_SAMPLES) begin
            phase_len   = remaining;
            settle_mode = 1'b1;
         end else if (phase_len > remaining - SETTLE_SAMPLES) begin
            phase_len = remaining - SETTLE_SAMPLES;
         end

         // first phase streams back to back against a long receiver hold-off
         if (sent == 0) begin
            idle_odds   = 0;
            hold_wanted = 1'b1;
         end else begin
            case ($urandom_range(0, 2))
               0: idle_odds = 0;
               1: idle_odds = 2;
               default: idle_odds = 6;
            endcase
         end

         repeat (phase_len) send_random_sample();
         sent += phase_len;
      end

      // drain
      req_ch.valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (results_owed != 0 && guard < DRAIN_LIMIT);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && results_owed == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/ecg_nlf_pkg.sv
rtl/ecg_nlf_if.sv
rtl/ecg_notch_leadoff_framer_unit.sv
tb/ecg_nlf_result_check.sv
tb/tb.sv
